[hdl/fdss_pkg.sv]
// Shared types, constants and helper functions for the seven-segment scanner.
package fdss_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int VALUE_W = 14;
    localparam int REM_W = 10;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] DWELL_RESET = 16'd5000;
    localparam logic [7:0] FRAMES_RESET = 8'd10;
    localparam logic [VALUE_W-1:0] READING_MAX = 14'd9999;

    localparam logic [VALUE_W-1:0] WEIGHT_THOUSANDS = 14'd1000;
    localparam logic [VALUE_W-1:0] WEIGHT_HUNDREDS = 14'd100;
    localparam logic [VALUE_W-1:0] WEIGHT_TENS = 14'd10;

    localparam logic [7:0] SEG_E = 8'h79;
    localparam logic [7:0] SEG_R = 8'h50;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DWELL_TICKS       = 8'd0,
        REG_FRAMES_PER_UPDATE = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_HUND,
        CONV_TENS
    } conv_phase_t;

    typedef struct packed {
        logic        func;
        logic [15:0] reading;
        logic        reading_valid;
    } in_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
    } out_t;

    // Snapshot request from the scan control to the display store
    typedef struct packed {
        logic               take;
        logic               valid;
        logic [VALUE_W-1:0] value;
    } snap_req_t;

    typedef struct packed {
        logic [3:0]         digit;
        logic [VALUE_W-1:0] rem;
    } step_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0: seg = 8'h3F;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5B;
            4'd3: seg = 8'h4F;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6D;
            4'd6: seg = 8'h7D;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7F;
            4'd9: seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // One decimal digit by parallel compares against the weight multiples
    function automatic step_t digit_step(input logic [VALUE_W-1:0] value,
                                         input logic [VALUE_W-1:0] weight);
        step_t s;
        s.digit = 4'd0;
        s.rem = value;
        for (int k = 1; k <= 9; k++) begin
            if (value >= VALUE_W'(k) * weight) begin
                s.digit = 4'(k);
                s.rem = value - VALUE_W'(k) * weight;
            end
        end
        return s;
    endfunction

endpackage

[hdl/fdss_display_store.sv]
// Digit pattern store with the snapshot conversion: thousands, then hundreds, then tens and units together.
module fdss_display_store
    import fdss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  snap_req_t              snap,
    input  logic [DIGIT_IDX_W-1:0] rd_idx,
    output logic [7:0]             rd_pattern
);

    logic [7:0]       shown_reg [NUM_DIGITS];
    logic [7:0]       shown_next [NUM_DIGITS];
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    conv_phase_t      phase_reg;
    conv_phase_t      phase_next;

    step_t step_thou;
    step_t step_hund;
    step_t step_tens;

    assign step_thou = digit_step(snap.value, WEIGHT_THOUSANDS);
    assign step_hund = digit_step(VALUE_W'(rem_reg), WEIGHT_HUNDREDS);
    assign step_tens = digit_step(VALUE_W'(rem_reg), WEIGHT_TENS);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (snap.take) begin
            phase_next = snap.valid ? CONV_HUND : CONV_IDLE;
        end else begin
            unique case (phase_reg)
                CONV_IDLE: phase_next = CONV_IDLE;
                CONV_HUND: phase_next = CONV_TENS;
                CONV_TENS: phase_next = CONV_IDLE;
                default:   phase_next = CONV_IDLE;
            endcase
        end
    end

    // pattern writes and remainder
    always_comb
    begin
        shown_next = shown_reg;
        rem_next = rem_reg;
        if (snap.take) begin
            if (snap.valid) begin
                shown_next[0] = seg_of(step_thou.digit);
                rem_next = step_thou.rem[REM_W-1:0];
            end else begin
                shown_next[0] = SEG_E;
                shown_next[1] = SEG_R;
                shown_next[2] = SEG_R;
                shown_next[3] = SEG_BLANK;
            end
        end else begin
            unique case (phase_reg)
                CONV_IDLE: ;
                CONV_HUND:
                begin
                    shown_next[1] = seg_of(step_hund.digit);
                    rem_next = step_hund.rem[REM_W-1:0];
                end
                CONV_TENS:
                begin
                    shown_next[2] = seg_of(step_tens.digit);
                    shown_next[3] = seg_of(step_tens.rem[3:0]);
                end
                default: ;
            endcase
        end
    end

    // forward the pattern written this cycle
    assign rd_pattern = shown_next[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= CONV_IDLE;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                shown_reg[k] <= SEG_BLANK;
            end
        end else begin
            phase_reg <= phase_next;
            shown_reg <= shown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

[hdl/four_digit_seven_segment_scanner_unit.sv]
// Top level of the four-digit multiplexed seven-segment scanner.
// Every accepted beat (measurement or tick) yields one result beat in the next cycle, and a
// new beat may be accepted in every cycle; the result register is the only stage, so in_stall
// follows out_stall while a result is held. A snapshot converts the latched reading to
// decimal with the thousands digit first, then hundreds, then tens and units together, so
// each digit is ready by the first tick that shows it. Configuration writes are always taken
// (cfg_ready is high); unknown indexes are ignored. There is no clearing pass after reset.
module four_digit_seven_segment_scanner_unit
    import fdss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_t                   out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0]            dwell_ticks_reg;
    logic [7:0]             frames_reg;
    logic [15:0]            pending_reading_reg;
    logic                   pending_valid_reg;
    logic [15:0]            dwell_count_reg;
    logic [15:0]            dwell_count_next;
    logic [DIGIT_IDX_W-1:0] digit_index_reg;
    logic [DIGIT_IDX_W-1:0] digit_index_next;
    logic [7:0]             frame_count_reg;
    logic [7:0]             frame_count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_t                   out_data_reg;
    out_t                   out_data_next;

    logic                   accept;
    logic                   tick;
    logic [16:0]            dwell_inc;
    logic [16:0]            dwell_limit;
    logic [7:0]             frame_load;
    logic [7:0]             frame_after;
    logic [DIGIT_IDX_W-1:0] digit_inc;
    logic [7:0]             pattern;
    snap_req_t              snap;

    assign cfg_ready = 1'b1;
    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign tick = accept && in_data.func;

    assign snap.take = tick && (digit_index_reg == '0) && (dwell_count_reg == '0)
                       && (frame_count_reg == '0);
    assign snap.valid = pending_valid_reg;
    assign snap.value = (pending_reading_reg > 16'(READING_MAX)) ? READING_MAX
                        : pending_reading_reg[VALUE_W-1:0];

    fdss_display_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .rd_idx     (digit_index_reg),
        .rd_pattern (pattern)
    );

    assign frame_load = (frames_reg == '0) ? 8'd1 : frames_reg;
    assign frame_after = snap.take ? frame_load : frame_count_reg;
    assign dwell_limit = (dwell_ticks_reg == '0) ? 17'd1 : {1'b0, dwell_ticks_reg};
    assign dwell_inc = {1'b0, dwell_count_reg} + 17'd1;
    assign digit_inc = digit_index_reg + DIGIT_IDX_W'(1);

    always_comb
    begin
        dwell_count_next = dwell_count_reg;
        digit_index_next = digit_index_reg;
        frame_count_next = frame_count_reg;
        if (tick) begin
            frame_count_next = frame_after;
            if (dwell_inc >= dwell_limit) begin
                dwell_count_next = '0;
                digit_index_next = digit_inc;
                // count down a frame on wrap to the leftmost digit
                if (digit_inc == '0 && frame_after != '0) begin
                    frame_count_next = frame_after - 8'd1;
                end
            end else begin
                dwell_count_next = dwell_inc[15:0];
            end
        end
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        if (accept) begin
            out_data_next.segments = pattern;
            out_data_next.digit_enable = 4'(4'b0001 << digit_index_reg);
        end
        // hold a stalled beat, drop a delivered one
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (out_stall) begin
            out_valid_next = out_valid_reg;
        end else begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dwell_ticks_reg <= DWELL_RESET;
            frames_reg <= FRAMES_RESET;
            pending_reading_reg <= '0;
            pending_valid_reg <= 1'b0;
            dwell_count_reg <= '0;
            digit_index_reg <= '0;
            frame_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DWELL_TICKS) begin
                    dwell_ticks_reg <= cfg_data;
                end else if (cfg_index == REG_FRAMES_PER_UPDATE) begin
                    frames_reg <= cfg_data[7:0];
                end
            end
            if (accept && !in_data.func) begin
                pending_reading_reg <= in_data.reading;
                pending_valid_reg <= in_data.reading_valid;
            end
            dwell_count_reg <= dwell_count_next;
            digit_index_reg <= digit_index_next;
            frame_count_reg <= frame_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

[hdl/fdss_checker.sv]
// Port-level checker for the scanner, bound to the top level.
module fdss_checker
    import fdss_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // exactly one digit lit per result beat
    a_onehot_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(out_data.digit_enable))
        else $error("digit_enable not one-hot");

    a_dp_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.segments[7] == 1'b0))
        else $error("decimal point lit");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // an accepted beat always produces a result beat next cycle
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat produced no result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind four_digit_seven_segment_scanner_unit fdss_checker u_fdss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
